>>> rtl/mp4_box_nal_deframer_macros.svh
// Assertion macros for the container deframer.
// Used by the top level; needs the aclk and aresetn names in scope.
`ifndef MP4_BOX_NAL_DEFRAMER_MACROS_SVH
`define MP4_BOX_NAL_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MBND_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MBND_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mbnd_pkg.sv
// Shared types and codes for the container box and NAL deframer.
// No dependencies; imported by every module of the block.
package mbnd_pkg;

    localparam int unsigned WORD_W = 32;
    localparam logic [WORD_W-1:0] SPLIT_TYPE_RESET = 32'h6D64_6174; // 'mdat'
    localparam logic [WORD_W-1:0] HDR_LEN = 32'd8;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_PLAIN  = 3'd1,
        PH_PREFIX = 3'd2,
        PH_NAL    = 3'd3,
        PH_ENDED  = 3'd4,
        PH_BAD    = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_PLAIN   = 3'd1,
        KIND_PREFIX  = 3'd2,
        KIND_NAL     = 3'd3,
        KIND_IGNORED = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ENDED   = 2'd1,
        ST_BAD_LEN = 2'd2,
        ST_OVERRUN = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_STREAM_LENGTH  = 2'd0,
        CFG_SPLIT_BOX_TYPE = 2'd1,
        CFG_SPLIT_ENABLE   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [WORD_W-1:0] stream_length;
        logic [WORD_W-1:0] split_box_type;
        logic              split_enable;
    } cfg_t;

    typedef struct packed {
        logic [7:0]        echo_byte;
        kind_t             byte_kind;
        logic [WORD_W-1:0] current_box_type;
        logic              header_done;
        logic              nal_first;
        logic              nal_last;
        logic [WORD_W-1:0] nal_size;
        status_t           status;
    } res_t;

endpackage

>>> rtl/mp4_box_nal_deframer.sv
// Top level of the container box and NAL deframer.
// Depends on mbnd_pkg, mbnd_parser, mbnd_out_reg and the assertion macro header.

// Byte-serial deframer for a box-structured media container. Every request on
// the s_ channel carries one stream byte and yields exactly one result request
// on the m_ channel, in the cycle after it is taken: the byte echoed with its kind
// (box header, plain payload, NAL length prefix, NAL payload or ignored), the
// current box type, header and NAL boundary flags, the NAL size and a status.
// The block sustains one byte per clock while m_ready is high; the rate is set
// by the single result register, which accepts a new byte in the same cycle
// that the held result is taken, so s_ready follows m_ready combinationally.
// Configuration is a plain write port that is taken at once: index 0 sets the
// stream length (0 for an unbounded stream) and restarts the stream byte count,
// index 1 the box type whose payload is split into NAL units, index 2 enables
// the split. Write it only while no byte is in flight. After a malformed box
// length or the end of the stream every byte is returned as ignored until reset.
`include "mp4_box_nal_deframer_macros.svh"

module mp4_box_nal_deframer
    import mbnd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration write port.
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [WORD_W-1:0] cfg_wr_data,
    // Input byte channel.
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_stream_byte,
    // Result channel.
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_echo_byte,
    output logic [2:0]        m_byte_kind,
    output logic [WORD_W-1:0] m_current_box_type,
    output logic              m_header_done,
    output logic              m_nal_first,
    output logic              m_nal_last,
    output logic [WORD_W-1:0] m_nal_size,
    output logic [1:0]        m_status
);

    cfg_t   cfg_reg;
    logic   reload;
    logic   s_accept;
    res_t   step_res;
    res_t   out_res;
    phase_t phase;

    // Configuration registers; a write to the stream length also restarts
    // the stream byte count inside the parser.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stream_length  <= '0;
            cfg_reg.split_box_type <= SPLIT_TYPE_RESET;
            cfg_reg.split_enable   <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_STREAM_LENGTH:  cfg_reg.stream_length  <= cfg_wr_data;
                CFG_SPLIT_BOX_TYPE: cfg_reg.split_box_type <= cfg_wr_data;
                CFG_SPLIT_ENABLE:   cfg_reg.split_enable   <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    assign reload   = cfg_wr_en && (cfg_index == CFG_STREAM_LENGTH);
    assign s_accept = s_valid && s_ready;

    // Parser state advances once per accepted byte, but not while a stream length write reloads it.
    mbnd_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .reload       (reload),
        .reload_value (cfg_wr_data),
        .step         (s_accept),
        .stream_byte  (s_stream_byte),
        .res          (step_res),
        .phase        (phase)
    );

    // The result of each byte is held here until the sink takes it.
    mbnd_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (s_accept),
        .in_res    (step_res),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_echo_byte        = out_res.echo_byte;
    assign m_byte_kind        = out_res.byte_kind;
    assign m_current_box_type = out_res.current_box_type;
    assign m_header_done      = out_res.header_done;
    assign m_nal_first        = out_res.nal_first;
    assign m_nal_last         = out_res.nal_last;
    assign m_nal_size         = out_res.nal_size;
    assign m_status           = out_res.status;

    // An empty result register must always take a new byte.
    `MBND_ASSERT_NOW(a_ready_when_empty, !m_valid, s_ready, "s_ready low with empty output")
    // Once the length is found malformed, every later byte reports it.
    `MBND_ASSERT_NEXT(a_bad_sticks, s_accept && (phase == PH_BAD),
        m_valid && (m_status == ST_BAD_LEN), "malformed state not reported")
    // Header completion only ever marks a header byte.
    `MBND_ASSERT_NOW(a_hdone_kind, m_valid && m_header_done,
        m_byte_kind == KIND_HEADER, "header_done on a non-header byte")
    // NAL boundary flags only ever mark NAL payload bytes.
    `MBND_ASSERT_NOW(a_nal_flags_kind, m_valid && (m_nal_first || m_nal_last),
        m_byte_kind == KIND_NAL, "NAL boundary flag outside NAL payload")

endmodule

>>> rtl/mbnd_parser.sv
// Parser state and per-byte step logic of the deframer.
// Depends on mbnd_pkg; the result leaves unregistered for the output stage.
module mbnd_parser
    import mbnd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              reload,
    input  logic [WORD_W-1:0] reload_value,
    input  logic              step,
    input  logic [7:0]        stream_byte,
    output res_t              res,
    output phase_t            phase
);

    phase_t            phase_reg, phase_next;
    logic [2:0]        fbc_reg, fbc_next;
    logic [WORD_W-1:0] shift_reg, shift_next;
    logic [WORD_W-1:0] box_type_reg, box_type_next;
    logic [WORD_W-1:0] box_left_reg, box_left_next;
    logic              box_unb_reg, box_unb_next;
    logic [WORD_W-1:0] nal_left_reg, nal_left_next;
    logic [WORD_W-1:0] nal_size_reg, nal_size_next;
    logic [WORD_W-1:0] stream_left_reg, stream_left_next;

    logic [WORD_W-1:0] shift_new;
    logic [2:0]        fbc_new;
    logic [WORD_W-1:0] box_dec;
    logic              box_done;
    logic              pre_over;
    logic [WORD_W-1:0] pre_sz;
    logic [WORD_W-1:0] nal_dec;
    logic              hdr_bad;
    logic              hdr_empty;
    logic              hdr_split;
    logic              ended_now;

    // Shared datapath terms for this byte.
    assign shift_new = {shift_reg[WORD_W-9:0], stream_byte};
    assign fbc_new   = fbc_reg + 3'd1;
    // An unbounded box never counts down and never ends.
    assign box_dec   = box_unb_reg ? box_left_reg :
                       ((box_left_reg != '0) ? box_left_reg - 1'b1 : '0);
    assign box_done  = !box_unb_reg && (box_dec == '0);
    assign pre_over  = !box_unb_reg && (shift_new > box_dec);
    assign pre_sz    = pre_over ? box_dec : shift_new;
    assign nal_dec   = (nal_left_reg != '0) ? nal_left_reg - 1'b1 : '0;
    // On the last header byte the length is held in box_left_reg.
    assign hdr_bad   = (box_left_reg != '0) && (box_left_reg < HDR_LEN);
    assign hdr_empty = (box_left_reg == HDR_LEN);
    assign hdr_split = cfg.split_enable && (shift_new == cfg.split_box_type);
    assign ended_now = (phase_reg == PH_ENDED) ||
                       ((cfg.stream_length != '0) && (stream_left_reg == '0));

    // Next-state logic.
    always_comb begin
        phase_next       = phase_reg;
        fbc_next         = fbc_reg;
        shift_next       = shift_reg;
        box_type_next    = box_type_reg;
        box_left_next    = box_left_reg;
        box_unb_next     = box_unb_reg;
        nal_left_next    = nal_left_reg;
        nal_size_next    = nal_size_reg;
        stream_left_next = stream_left_reg;
        if (phase_reg == PH_BAD) begin
            phase_next = PH_BAD;
        end else if (ended_now) begin
            phase_next = PH_ENDED;
        end else begin
            if (cfg.stream_length != '0) begin
                stream_left_next = stream_left_reg - 1'b1;
            end
            case (phase_reg)
                PH_HEADER: begin
                    shift_next = shift_new;
                    fbc_next   = fbc_new;
                    if (fbc_new == 3'd4) begin
                        box_left_next = shift_new;
                        shift_next    = '0;
                    end else if (fbc_new == 3'd0) begin
                        box_type_next = shift_new;
                        shift_next    = '0;
                        if (hdr_bad) begin
                            phase_next    = PH_BAD;
                            box_left_next = '0;
                        end else begin
                            box_unb_next  = (box_left_reg == '0);
                            box_left_next = (box_left_reg == '0) ? '0 : box_left_reg - HDR_LEN;
                            if (hdr_empty) begin
                                phase_next = PH_HEADER;
                            end else if (hdr_split) begin
                                phase_next = PH_PREFIX;
                            end else begin
                                phase_next = PH_PLAIN;
                            end
                        end
                    end
                end
                PH_PLAIN: begin
                    box_left_next = box_dec;
                    if (box_done) begin
                        phase_next = PH_HEADER;
                        fbc_next   = '0;
                        shift_next = '0;
                    end
                end
                PH_PREFIX: begin
                    shift_next    = shift_new;
                    fbc_next      = fbc_new;
                    box_left_next = box_dec;
                    if (fbc_new[2]) begin
                        nal_size_next = pre_sz;
                        nal_left_next = pre_sz;
                        if (box_done) begin
                            phase_next = PH_HEADER;
                            fbc_next   = '0;
                            shift_next = '0;
                        end else if (pre_sz == '0) begin
                            phase_next = PH_PREFIX;
                            fbc_next   = '0;
                            shift_next = '0;
                        end else begin
                            phase_next = PH_NAL;
                        end
                    end else if (box_done) begin
                        phase_next = PH_HEADER;
                        fbc_next   = '0;
                        shift_next = '0;
                    end
                end
                PH_NAL: begin
                    nal_left_next = nal_dec;
                    box_left_next = box_dec;
                    if (nal_dec == '0) begin
                        phase_next = box_done ? PH_HEADER : PH_PREFIX;
                        fbc_next   = '0;
                        shift_next = '0;
                    end else if (box_done) begin
                        phase_next = PH_HEADER;
                        fbc_next   = '0;
                        shift_next = '0;
                    end
                end
                default: begin
                    phase_next = PH_BAD;
                end
            endcase
        end
    end

    // Result fields for this byte.
    always_comb begin
        res                  = '0;
        res.echo_byte        = stream_byte;
        res.byte_kind        = KIND_IGNORED;
        res.status           = ST_OK;
        res.current_box_type = box_type_next;
        if (phase_reg == PH_BAD) begin
            res.status = ST_BAD_LEN;
        end else if (ended_now) begin
            res.status = ST_ENDED;
        end else begin
            case (phase_reg)
                PH_HEADER: begin
                    res.byte_kind = KIND_HEADER;
                    if (fbc_new == 3'd0) begin
                        res.header_done = 1'b1;
                        if (hdr_bad) begin
                            res.status = ST_BAD_LEN;
                        end
                    end
                end
                PH_PLAIN: begin
                    res.byte_kind = KIND_PLAIN;
                end
                PH_PREFIX: begin
                    res.byte_kind = KIND_PREFIX;
                    if (fbc_new[2]) begin
                        res.nal_size = pre_sz;
                        if (pre_over) begin
                            res.status = ST_OVERRUN;
                        end
                    end else if (box_done) begin
                        res.status = ST_OVERRUN;
                    end
                end
                PH_NAL: begin
                    res.byte_kind = KIND_NAL;
                    res.nal_size  = nal_size_reg;
                    res.nal_first = (nal_left_reg == nal_size_reg);
                    res.nal_last  = (nal_dec == '0);
                end
                default: begin
                    res.status = ST_BAD_LEN;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HEADER;
            fbc_reg         <= '0;
            shift_reg       <= '0;
            box_type_reg    <= '0;
            box_left_reg    <= '0;
            box_unb_reg     <= 1'b0;
            nal_left_reg    <= '0;
            nal_size_reg    <= '0;
            stream_left_reg <= '0;
        end else if (reload) begin
            stream_left_reg <= reload_value;
        end else if (step) begin
            phase_reg       <= phase_next;
            fbc_reg         <= fbc_next;
            shift_reg       <= shift_next;
            box_type_reg    <= box_type_next;
            box_left_reg    <= box_left_next;
            box_unb_reg     <= box_unb_next;
            nal_left_reg    <= nal_left_next;
            nal_size_reg    <= nal_size_next;
            stream_left_reg <= stream_left_next;
        end
    end

    assign phase = phase_reg;

endmodule

>>> rtl/mbnd_out_reg.sv
// Result register of the deframer with its valid/ready handshake.
// Depends on mbnd_pkg for the result record.
module mbnd_out_reg
    import mbnd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic load,
    input  res_t in_res,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    logic valid_reg, valid_next;
    res_t res_reg;

    // Room for a new result when empty or when the held one leaves now.
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= in_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule
